@@ src/rar_pkg.sv @@
// Shared types for the rational arithmetic reduce unit: request/response
// payloads, operation and status codes, controller-to-datapath command/status.
// No dependencies.
`default_nettype none

package rar_pkg;

   // Operation selector carried in each request
   typedef enum logic [1:0] {
      MODE_NORM = 2'd0,
      MODE_SUB  = 2'd1,
      MODE_MUL  = 2'd2,
      MODE_DIV  = 2'd3
   } mode_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DEN_ZERO = 2'd1,
      STATUS_DIV_ZERO = 2'd2
   } status_type;

   localparam int FIELD_W = 16;

   typedef logic signed [FIELD_W-1:0] field_type;
   typedef logic signed [32:0]        num_type;
   typedef logic [30:0]               den_type;

   typedef struct packed {
      mode_type  mode;
      field_type a_num;
      field_type a_den;
      field_type b_num;
      field_type b_den;
   } req_type;

   typedef struct packed {
      num_type    res_num;
      den_type    res_den;
      status_type status;
   } rsp_type;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_WB,
      OP_GCD_INIT,
      OP_GCD_STEP,
      OP_GCD_SHIFT,
      OP_DIV_INIT_NUM,
      OP_DIV_INIT_DEN,
      OP_DIV_STEP,
      OP_OUT
   } dp_op_type;

   // Operand pair fed to the shared multiplier
   typedef enum logic [2:0] {
      MUL_AN_BD,
      MUL_BN_AD,
      MUL_AD_BD,
      MUL_AN_BN,
      MUL_AD_BN
   } mul_sel_type;

   // Where a registered product (or operand copy) lands
   typedef enum logic [1:0] {
      WB_COPY,
      WB_RN,
      WB_RN_SUB,
      WB_RD
   } wb_sel_type;

   typedef struct packed {
      dp_op_type   op;
      mul_sel_type mul_sel;
      wb_sel_type  wb_sel;
      status_type  status;
   } dp_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     den_zero;
      logic     div_zero;
      logic     u_zero;
      logic     k_zero;
      logic     div_last;
   } dp_sts_type;

endpackage

`default_nettype wire

@@ src/rar_dpath.sv @@
// Datapath of the rational arithmetic reduce unit: operand registers, shared
// multiplier, binary gcd, restoring divider and response register.
// Depends on rar_pkg.
`default_nettype none

module rar_dpath #(
   parameter int OPERAND_WIDTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rar_pkg::req_type     req_data,
   input  wire rar_pkg::dp_cmd_type  cmd,
   output rar_pkg::dp_sts_type       sts,
   output rar_pkg::rsp_type          rsp_data
);

   localparam int W  = OPERAND_WIDTH;
   localparam int OW = W + 1;          // operand after sign fix
   localparam int SW = 2 * W + 1;      // signed product / difference
   localparam int MW = 2 * W;          // magnitude
   localparam int KW = $clog2(MW + 1); // common power-of-two count
   localparam int CW = $clog2(MW);     // divider bit counter

   // Read a field as a W-bit two's complement value, one bit wider
   function automatic logic signed [OW-1:0] get_op(input rar_pkg::field_type f);
      logic [31:0] z;
      z = 32'(unsigned'(f));
      return {z[W-1], z[W-1:0]};
   endfunction

   rar_pkg::mode_type      mode_ff;
   logic signed [OW-1:0]   an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [OW-1:0]   an_ld, ad_ld, bn_ld, bd_ld;
   logic signed [OW-1:0]   mul_x, mul_y;
   logic signed [2*OW-1:0] mul_full;
   logic signed [SW-1:0]   prod_ff;
   logic signed [SW-1:0]   rn_ff, rd_ff;
   logic signed [SW-1:0]   rn_abs, rd_abs;
   logic [MW-1:0]          u_ff, v_ff;
   logic [KW-1:0]          k_ff;
   logic                   neg_ff;
   logic [MW:0]            diff_uv, diff_vu;
   logic [MW-1:0]          rem_ff, quo_ff, qnum_ff;
   logic [CW-1:0]          cnt_ff;
   logic [MW:0]            div_sh;
   logic [MW+1:0]          div_trial;
   logic signed [MW:0]     num_s;
   rar_pkg::rsp_type       rsp_ff;

   // Operand capture with the denominator signs folded into the numerators
   always_comb begin
      an_ld = get_op(req_data.a_num);
      ad_ld = get_op(req_data.a_den);
      bn_ld = get_op(req_data.b_num);
      bd_ld = get_op(req_data.b_den);
      if (ad_ld[OW-1]) begin
         an_ld = -an_ld;
         ad_ld = -ad_ld;
      end
      if (bd_ld[OW-1]) begin
         bn_ld = -bn_ld;
         bd_ld = -bd_ld;
      end
   end

   // Shared multiplier, product registered every cycle
   always_comb begin
      case (cmd.mul_sel)
         rar_pkg::MUL_AN_BD: begin mul_x = an_ff; mul_y = bd_ff; end
         rar_pkg::MUL_BN_AD: begin mul_x = bn_ff; mul_y = ad_ff; end
         rar_pkg::MUL_AD_BD: begin mul_x = ad_ff; mul_y = bd_ff; end
         rar_pkg::MUL_AN_BN: begin mul_x = an_ff; mul_y = bn_ff; end
         rar_pkg::MUL_AD_BN: begin mul_x = ad_ff; mul_y = bn_ff; end
         default:            begin mul_x = an_ff; mul_y = bd_ff; end
      endcase
      mul_full = mul_x * mul_y;
   end

   // Magnitudes, gcd compares, divider trial subtract, signed numerator
   always_comb begin
      rn_abs    = rn_ff[SW-1] ? -rn_ff : rn_ff;
      rd_abs    = rd_ff[SW-1] ? -rd_ff : rd_ff;
      diff_uv   = {1'b0, u_ff} - {1'b0, v_ff};
      diff_vu   = {1'b0, v_ff} - {1'b0, u_ff};
      div_sh    = {rem_ff, quo_ff[MW-1]};
      div_trial = {1'b0, div_sh} - {2'b00, v_ff};
      num_s     = signed'({1'b0, qnum_ff});
      if (neg_ff) begin
         num_s = -num_s;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_full[SW-1:0];
      unique case (cmd.op)
         rar_pkg::OP_LOAD: begin
            mode_ff <= req_data.mode;
            an_ff   <= an_ld;
            ad_ff   <= ad_ld;
            bn_ff   <= bn_ld;
            bd_ff   <= bd_ld;
         end
         rar_pkg::OP_WB: begin
            unique case (cmd.wb_sel)
               rar_pkg::WB_COPY: begin
                  rn_ff <= SW'(an_ff);
                  rd_ff <= SW'(ad_ff);
               end
               rar_pkg::WB_RN:     rn_ff <= prod_ff;
               rar_pkg::WB_RN_SUB: rn_ff <= rn_ff - prod_ff;
               rar_pkg::WB_RD:     rd_ff <= prod_ff;
               default:            rd_ff <= prod_ff;
            endcase
         end
         rar_pkg::OP_GCD_INIT: begin
            u_ff   <= rn_abs[MW-1:0];
            v_ff   <= rd_abs[MW-1:0];
            neg_ff <= rn_ff[SW-1] ^ rd_ff[SW-1];
            k_ff   <= '0;
         end
         // One binary gcd step
         rar_pkg::OP_GCD_STEP: begin
            priority if (!u_ff[0] && !v_ff[0]) begin
               u_ff <= u_ff >> 1;
               v_ff <= v_ff >> 1;
               k_ff <= k_ff + KW'(1);
            end else if (!u_ff[0]) begin
               u_ff <= u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_ff <= v_ff >> 1;
            end else if (!diff_uv[MW]) begin
               u_ff <= {1'b0, diff_uv[MW-1:1]};
            end else begin
               v_ff <= {1'b0, diff_vu[MW-1:1]};
            end
         end
         // Restore the common power of two, one bit a cycle
         rar_pkg::OP_GCD_SHIFT: begin
            v_ff <= v_ff << 1;
            k_ff <= k_ff - KW'(1);
         end
         rar_pkg::OP_DIV_INIT_NUM: begin
            quo_ff <= rn_abs[MW-1:0];
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         rar_pkg::OP_DIV_INIT_DEN: begin
            qnum_ff <= quo_ff;
            quo_ff  <= rd_abs[MW-1:0];
            rem_ff  <= '0;
            cnt_ff  <= '0;
         end
         // Restoring division by the gcd, one quotient bit a cycle
         rar_pkg::OP_DIV_STEP: begin
            if (!div_trial[MW+1]) begin
               rem_ff <= div_trial[MW-1:0];
               quo_ff <= {quo_ff[MW-2:0], 1'b1};
            end else begin
               rem_ff <= div_sh[MW-1:0];
               quo_ff <= {quo_ff[MW-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + CW'(1);
         end
         rar_pkg::OP_OUT: begin
            if (cmd.status == rar_pkg::STATUS_OK) begin
               rsp_ff.res_num <= rar_pkg::num_type'(num_s);
               rsp_ff.res_den <= rar_pkg::den_type'(quo_ff);
            end else begin
               rsp_ff.res_num <= '0;
               rsp_ff.res_den <= '0;
            end
            rsp_ff.status <= cmd.status;
         end
         default: begin
         end
      endcase
   end

   // Status back to the controller
   always_comb begin
      sts.mode     = mode_ff;
      sts.den_zero = (ad_ff == '0) || ((mode_ff != rar_pkg::MODE_NORM) && (bd_ff == '0));
      sts.div_zero = (mode_ff == rar_pkg::MODE_DIV) && (bn_ff == '0);
      sts.u_zero   = (u_ff == '0);
      sts.k_zero   = (k_ff == '0);
      sts.div_last = (cnt_ff == CW'(MW - 1));
   end

   assign rsp_data = rsp_ff;

   // The gcd and divider never run against a zero divisor
   a_gcd_v_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.op == rar_pkg::OP_GCD_STEP |-> v_ff != '0)
      else $error("gcd step with zero second operand");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.op == rar_pkg::OP_DIV_STEP |-> v_ff != '0)
      else $error("divide step with zero divisor");

   a_den_positive: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == rar_pkg::OP_OUT && cmd.status == rar_pkg::STATUS_OK)
      |=> rsp_ff.res_den != '0)
      else $error("ok result with zero denominator");

endmodule

`default_nettype wire

@@ src/rar_ctrl.sv @@
// Controller of the rational arithmetic reduce unit: sequences load, checks,
// products, gcd and the two divisions, and owns the response valid.
// Depends on rar_pkg.
`default_nettype none

module rar_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire rar_pkg::dp_sts_type  sts,
   output rar_pkg::dp_cmd_type       cmd
);

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_CHECK    = 11'b000_0000_0010,
      ST_ARITH    = 11'b000_0000_0100,
      ST_GCD_INIT = 11'b000_0000_1000,
      ST_GCD      = 11'b000_0001_0000,
      ST_GSHIFT   = 11'b000_0010_0000,
      ST_DINIT_N  = 11'b000_0100_0000,
      ST_DIV_N    = 11'b000_1000_0000,
      ST_DINIT_D  = 11'b001_0000_0000,
      ST_DIV_D    = 11'b010_0000_0000,
      ST_DONE     = 11'b100_0000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           step_ff, step_in;
   rar_pkg::status_type  err_ff, err_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 arith_last;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      arith_last   = 1'b0;
      cmd.op       = rar_pkg::OP_NONE;
      cmd.mul_sel  = rar_pkg::MUL_AN_BD;
      cmd.wb_sel   = rar_pkg::WB_COPY;
      cmd.status   = err_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = rar_pkg::OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         // Zero denominator wins over division by zero
         ST_CHECK: begin
            step_in = 2'd0;
            priority if (sts.den_zero) begin
               err_in   = rar_pkg::STATUS_DEN_ZERO;
               state_in = ST_DONE;
            end else if (sts.div_zero) begin
               err_in   = rar_pkg::STATUS_DIV_ZERO;
               state_in = ST_DONE;
            end else begin
               err_in   = rar_pkg::STATUS_OK;
               state_in = ST_ARITH;
            end
         end
         // Product schedule: multiply in one step, write back in the next
         ST_ARITH: begin
            step_in = step_ff + 2'd1;
            unique case (sts.mode)
               rar_pkg::MODE_NORM: begin
                  cmd.op     = rar_pkg::OP_WB;
                  cmd.wb_sel = rar_pkg::WB_COPY;
                  arith_last = 1'b1;
               end
               rar_pkg::MODE_SUB: begin
                  case (step_ff)
                     2'd0: cmd.mul_sel = rar_pkg::MUL_AN_BD;
                     2'd1: begin
                        cmd.mul_sel = rar_pkg::MUL_BN_AD;
                        cmd.op      = rar_pkg::OP_WB;
                        cmd.wb_sel  = rar_pkg::WB_RN;
                     end
                     2'd2: begin
                        cmd.mul_sel = rar_pkg::MUL_AD_BD;
                        cmd.op      = rar_pkg::OP_WB;
                        cmd.wb_sel  = rar_pkg::WB_RN_SUB;
                     end
                     default: begin
                        cmd.op     = rar_pkg::OP_WB;
                        cmd.wb_sel = rar_pkg::WB_RD;
                        arith_last = 1'b1;
                     end
                  endcase
               end
               rar_pkg::MODE_MUL: begin
                  case (step_ff)
                     2'd0: cmd.mul_sel = rar_pkg::MUL_AN_BN;
                     2'd1: begin
                        cmd.mul_sel = rar_pkg::MUL_AD_BD;
                        cmd.op      = rar_pkg::OP_WB;
                        cmd.wb_sel  = rar_pkg::WB_RN;
                     end
                     default: begin
                        cmd.op     = rar_pkg::OP_WB;
                        cmd.wb_sel = rar_pkg::WB_RD;
                        arith_last = 1'b1;
                     end
                  endcase
               end
               default: begin
                  case (step_ff)
                     2'd0: cmd.mul_sel = rar_pkg::MUL_AN_BD;
                     2'd1: begin
                        cmd.mul_sel = rar_pkg::MUL_AD_BN;
                        cmd.op      = rar_pkg::OP_WB;
                        cmd.wb_sel  = rar_pkg::WB_RN;
                     end
                     default: begin
                        cmd.op     = rar_pkg::OP_WB;
                        cmd.wb_sel = rar_pkg::WB_RD;
                        arith_last = 1'b1;
                     end
                  endcase
               end
            endcase
            if (arith_last) begin
               state_in = ST_GCD_INIT;
            end
         end
         ST_GCD_INIT: begin
            cmd.op   = rar_pkg::OP_GCD_INIT;
            state_in = ST_GCD;
         end
         ST_GCD: begin
            if (sts.u_zero) begin
               state_in = ST_GSHIFT;
            end else begin
               cmd.op = rar_pkg::OP_GCD_STEP;
            end
         end
         ST_GSHIFT: begin
            if (sts.k_zero) begin
               state_in = ST_DINIT_N;
            end else begin
               cmd.op = rar_pkg::OP_GCD_SHIFT;
            end
         end
         ST_DINIT_N: begin
            cmd.op   = rar_pkg::OP_DIV_INIT_NUM;
            state_in = ST_DIV_N;
         end
         ST_DIV_N: begin
            cmd.op = rar_pkg::OP_DIV_STEP;
            if (sts.div_last) begin
               state_in = ST_DINIT_D;
            end
         end
         ST_DINIT_D: begin
            cmd.op   = rar_pkg::OP_DIV_INIT_DEN;
            state_in = ST_DIV_D;
         end
         ST_DIV_D: begin
            cmd.op = rar_pkg::OP_DIV_STEP;
            if (sts.div_last) begin
               state_in = ST_DONE;
            end
         end
         // Hand over once the response register is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = rar_pkg::OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 2'd0;
         err_ff       <= rar_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_CHECK)
      else $error("accepted request did not start the check");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && rsp_valid_ff && !rsp_ready |=> state_ff == ST_DONE)
      else $error("result overwrote a response still pending");

endmodule

`default_nettype wire

@@ src/rational_arith_reduce_unit.sv @@
// Rational arithmetic reduce unit: one request (mode, fraction a, fraction b)
// gives one response (numerator with sign, positive denominator, status) in
// lowest terms. Operands are read as OPERAND_WIDTH-bit two's complement. Works
// on one request at a time: after load and check, a shared multiplier forms
// the products, a binary gcd runs one subtract-and-shift step a cycle and
// then the restoring shifts, and one restoring divider forms each of the
// two quotients in turn. An error status skips the products, gcd and
// divisions. A finished response waits in its output register while the
// next request is taken.
// Depends on rar_pkg, rar_ctrl, rar_dpath.
`default_nettype none

module rational_arith_reduce_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rar_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rar_pkg::rsp_type       rsp_data
);

   rar_pkg::dp_cmd_type cmd;
   rar_pkg::dp_sts_type sts;

   rar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rar_dpath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Testbench for rational_arith_reduce_unit: directed fraction table, then bursty
// random requests, checked against hand answers or an in-bench reduction model.
// Depends on rar_pkg and the unit's RTL.

module tb;
   import rar_pkg::*;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // One row of the directed table; literal rows carry the answer by hand
   typedef struct {
      req_type req;
      bit      literal;
      rsp_type rsp;
   } frac_row_type;

   frac_row_type dir_rows[$];
   rsp_type      fractions_due[$];
   int           fail_count = 0;
   int           burst_left = 0;
   int           stall_left = 0;
   int           stall_mood = 0;
   int           mood_timer = 0;

   rational_arith_reduce_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Clock and reset
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Run limit
   initial begin
      #15_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Exact result of one request: sign on numerator, positive denominator,
   // both divided by their gcd; errors give 0/0 with a status code
   function automatic rsp_type reduce_fraction(req_type r);
      longint            an, ad, bn, bd, rn, rd;
      longint unsigned   mag, den, x, y, t;
      bit                neg;
      rsp_type           o;
      o        = '0;
      o.status = STATUS_OK;
      an = r.a_num;
      ad = r.a_den;
      bn = r.b_num;
      bd = r.b_den;
      if (ad == 0 || (r.mode != MODE_NORM && bd == 0)) begin
         o.status = STATUS_DEN_ZERO;
         return o;
      end
      if (ad < 0) begin
         an = -an;
         ad = -ad;
      end
      if (bd < 0) begin
         bn = -bn;
         bd = -bd;
      end
      case (r.mode)
         MODE_NORM: begin
            rn = an;
            rd = ad;
         end
         MODE_SUB: begin
            rn = an * bd - bn * ad;
            rd = ad * bd;
         end
         MODE_MUL: begin
            rn = an * bn;
            rd = ad * bd;
         end
         default: begin
            if (bn == 0) begin
               o.status = STATUS_DIV_ZERO;
               return o;
            end
            rn = an * bd;
            rd = ad * bn;
            if (rd < 0) begin
               rn = -rn;
               rd = -rd;
            end
         end
      endcase
      neg = (rn < 0);
      mag = neg ? longint'(-rn) : longint'(rn);
      den = rd;
      // Euclid on magnitudes; den is never zero here
      x = mag;
      y = den;
      while (y != 0) begin
         t = y;
         y = x % y;
         x = t;
      end
      mag = mag / x;
      den = den / x;
      o.res_num = neg ? num_type'(-longint'(mag)) : num_type'(mag);
      o.res_den = den_type'(den);
      return o;
   endfunction

   task automatic add_row(mode_type m, int an, int ad, int bn, int bd, bit literal,
                          longint rn, longint rd, status_type st);
      frac_row_type row;
      row.req.mode    = m;
      row.req.a_num   = field_type'(an);
      row.req.a_den   = field_type'(ad);
      row.req.b_num   = field_type'(bn);
      row.req.b_den   = field_type'(bd);
      row.literal     = literal;
      row.rsp.res_num = num_type'(rn);
      row.rsp.res_den = den_type'(rd);
      row.rsp.status  = st;
      dir_rows.push_back(row);
   endtask

   // Operand mix: full range, small values, shifted values, extremes, and
   // products of small factors so the gcd has real work to do
   function automatic field_type rand_operand();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return field_type'($urandom());
         4, 5, 6:    return field_type'(int'($urandom_range(0, 60)) - 30);
         7:          return field_type'((int'($urandom_range(0, 40)) - 20)
                                        <<< $urandom_range(0, 10));
         8: begin
            case ($urandom_range(0, 4))
               0:       return field_type'(-32768);
               1:       return field_type'(32767);
               2:       return field_type'(-1);
               3:       return field_type'(1);
               default: return field_type'(0);
            endcase
         end
         default: return field_type'(int'($urandom_range(1, 180)) *
                                     int'($urandom_range(1, 180)) *
                                     ($urandom_range(0, 1) ? -1 : 1));
      endcase
   endfunction

   function automatic field_type rand_den();
      if ($urandom_range(0, 24) == 0)
         return '0;
      return rand_operand();
   endfunction

   // Present one request and hold it until taken; queue its answer then
   task automatic send_fraction(req_type r, rsp_type answer);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      fractions_due.push_back(answer);
   endtask

   // Burst pacing: back-to-back inside a burst, a gap of random size between
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      case ($urandom_range(0, 2))
         0:       gap = 0;
         1:       gap = $urandom_range(1, 8);
         default: gap = $urandom_range(20, 180);
      endcase
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left = $urandom_range(0, 11);
   endtask

   // Hold off until every outstanding response is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (fractions_due.size() != 0) @(posedge clock);
   endtask

   // Stimulus
   initial begin
      req_type r;
      // normalize, zero and sign handling
      add_row(MODE_NORM, 0, 5, 0, 0, 1'b1, 0, 1, STATUS_OK);
      add_row(MODE_NORM, 6, -4, 0, 0, 1'b1, -3, 2, STATUS_OK);
      add_row(MODE_NORM, 5, 0, 1, 1, 1'b1, 0, 0, STATUS_DEN_ZERO);
      add_row(MODE_NORM, 7, 3, 9, 0, 1'b1, 7, 3, STATUS_OK);
      add_row(MODE_NORM, -32768, -32768, 0, 0, 1'b1, 1, 1, STATUS_OK);
      add_row(MODE_NORM, 32767, -32768, 0, 0, 1'b1, -32767, 32768, STATUS_OK);
      // zero denominators, and their precedence over division by zero
      add_row(MODE_SUB, 1, 0, 1, 1, 1'b1, 0, 0, STATUS_DEN_ZERO);
      add_row(MODE_SUB, 1, 1, 1, 0, 1'b1, 0, 0, STATUS_DEN_ZERO);
      add_row(MODE_MUL, 3, 4, 5, 0, 1'b1, 0, 0, STATUS_DEN_ZERO);
      add_row(MODE_DIV, 3, 4, 0, 7, 1'b1, 0, 0, STATUS_DIV_ZERO);
      add_row(MODE_DIV, 3, 0, 0, 7, 1'b1, 0, 0, STATUS_DEN_ZERO);
      add_row(MODE_DIV, 3, 4, 0, 0, 1'b1, 0, 0, STATUS_DEN_ZERO);
      // extremes of the result fields
      add_row(MODE_MUL, -32768, 1, -32768, 1, 1'b1, 1073741824, 1, STATUS_OK);
      add_row(MODE_MUL, 1, -32768, 1, -32768, 1'b1, 1, 1073741824, STATUS_OK);
      add_row(MODE_SUB, -32768, 1, 32767, 1, 1'b1, -65535, 1, STATUS_OK);
      add_row(MODE_DIV, 1, 1, -1, 1, 1'b1, -1, 1, STATUS_OK);
      add_row(MODE_DIV, 0, 7, 3, 5, 1'b1, 0, 1, STATUS_OK);
      add_row(MODE_SUB, 3, 4, 3, 4, 1'b1, 0, 1, STATUS_OK);
      // checked by the model
      add_row(MODE_SUB, -32768, 32767, 32767, -32768, 1'b0, 0, 0, STATUS_OK);
      add_row(MODE_SUB, 32767, -32768, -32768, 32767, 1'b0, 0, 0, STATUS_OK);
      add_row(MODE_DIV, -32768, 32767, 32767, -32768, 1'b0, 0, 0, STATUS_OK);
      add_row(MODE_MUL, 32767, 32767, -32768, -1, 1'b0, 0, 0, STATUS_OK);
      add_row(MODE_DIV, 12, -18, -8, 30, 1'b0, 0, 0, STATUS_OK);
      add_row(MODE_MUL, 32767, 1, 32767, 1, 1'b0, 0, 0, STATUS_OK);
      add_row(MODE_SUB, 1, 32767, 1, 32766, 1'b0, 0, 0, STATUS_OK);

      while (reset) @(posedge clock);

      foreach (dir_rows[i]) begin
         send_fraction(dir_rows[i].req,
                       dir_rows[i].literal ? dir_rows[i].rsp
                                           : reduce_fraction(dir_rows[i].req));
         pace_sender();
      end
      drain_responses();

      // Random requests
      for (int n = 0; n < 600; n++) begin
         if (n == 300)
            drain_responses();
         r.mode  = mode_type'($urandom_range(0, 3));
         r.a_num = rand_operand();
         r.a_den = rand_den();
         r.b_num = (r.mode == MODE_DIV && $urandom_range(0, 19) == 0) ? '0
                                                                       : rand_operand();
         r.b_den = rand_den();
         send_fraction(r, reduce_fraction(r));
         pace_sender();
      end
      req_valid <= 1'b0;

      // Wait out the last responses, then allow for stray ones
      while (fractions_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Response stalls: the mood (none, light, heavy) is redrawn when mood_timer wraps
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
         stall_mood <= 0;
         mood_timer <= 0;
      end else begin
         mood_timer <= (mood_timer == 699) ? 0 : mood_timer + 1;
         if (mood_timer == 699)
            stall_mood <= $urandom_range(0, 2);
         if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (stall_mood != 0 && $urandom_range(0, 9) < stall_mood * 3)
               stall_left <= $urandom_range(1, (stall_mood == 2) ? 40 : 6);
         end
      end
   end

   // Response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (fractions_due.size() == 0) begin
            $error("unexpected response: res_num %0d res_den %0d status %0d",
                   rsp_data.res_num, rsp_data.res_den, rsp_data.status);
            fail_count++;
         end else begin
            want = fractions_due.pop_front();
            if (rsp_data.res_num !== want.res_num) begin
               $error("res_num: expected %0d, actual %0d", want.res_num, rsp_data.res_num);
               fail_count++;
            end
            if (rsp_data.res_den !== want.res_den) begin
               $error("res_den: expected %0d, actual %0d", want.res_den, rsp_data.res_den);
               fail_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               fail_count++;
            end
         end
      end
   end

endmodule

@@ sim.f @@
src/rar_pkg.sv
src/rar_dpath.sv
src/rar_ctrl.sv
src/rational_arith_reduce_unit.sv
dv/tb.sv
